/* rtl/cpsc_pkg.sv */
// Shared types and constants for the CA PMT service classifier.
// Used by cpsc_parser, cpsc_out_buf and ca_pmt_service_classifier; no dependencies.

package cpsc_pkg;

	localparam int DEF_MAX_OBJECT_BYTES = 4096;

	// Output word width: 37 result bits padded to whole bytes.
	localparam int OUT_TDATA_W = 40;

	localparam logic [23:0] CAPMT_TAG = 24'h9F8032;
	localparam int LEN_EXT_BIT = 7;
	localparam logic [7:0] TAG_CA = 8'h09;
	localparam logic [7:0] TAG_PRIVATE = 8'h81;
	localparam logic [7:0] PRIV_MIN_LEN = 8'd8;
	localparam logic [7:0] CMD_DESCRAMBLE_OK = 8'h01;
	localparam logic [7:0] LM_FIRST = 8'h01;
	localparam logic [7:0] LM_ONLY = 8'h03;
	localparam logic [7:0] LM_UPDATE = 8'h05;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_BODY,
		PH_SKIP
	} cpsc_phase_t;

	typedef struct packed {
		logic        is_capmt;
		logic        selects_service;
		logic [15:0] program_number;
		logic [15:0] provider_id;
		logic        free_to_air;
		logic        switch_request;
		logic        oversize;
	} cpsc_result_t;

endpackage

/* rtl/ca_pmt_service_classifier.sv */
// CA PMT service classifier: parses a TLV byte stream one word per cycle while input is not stalled.
// Instantiates cpsc_parser and cpsc_out_buf; depends on cpsc_pkg.

// The block takes one byte word per cycle on the s_ stream and gives one result word on
// the m_ stream at the end of each object; a word with s_tuser set drops any partial
// object. A word passes an input register, then the parser updates its state and, at an
// object end, hands the result to the output buffer on that update. The sustained rate is
// one word per cycle, set by the per-word parser state update; a one-word skid stage
// keeps input flowing while a result waits, and input stalls only when both output words
// are full. Objects whose total size exceeds MAX_OBJECT_BYTES are skipped and reported as
// oversize. No clearing pass is needed after reset.

module ca_pmt_service_classifier #(
	parameter int MAX_OBJECT_BYTES = cpsc_pkg::DEF_MAX_OBJECT_BYTES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // rx_byte[7:0]
	input  logic                             s_tuser,  // restart
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// is_capmt, selects_service, program_number[15:0], provider_id[15:0],
	// free_to_air, switch_request, oversize, zero padding
	output logic [cpsc_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic valid_s1, take_s1, res_valid, skid_full;
	logic [7:0] byte_s1;
	logic restart_s1;
	cpsc_pkg::cpsc_result_t res, out_res;

	assign take_s1 = valid_s1 && !skid_full;
	assign s_tready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			restart_s1 <= s_tuser;
		end
	end

	cpsc_parser #(
		.MAX_OBJECT_BYTES(MAX_OBJECT_BYTES)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (take_s1),
		.rx_byte  (byte_s1),
		.restart  (restart_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	cpsc_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_data  (res),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_data (out_res),
		.skid_full(skid_full)
	);

	assign m_tdata = {3'b000, out_res.oversize, out_res.switch_request, out_res.free_to_air,
		out_res.provider_id, out_res.program_number, out_res.selects_service,
		out_res.is_capmt};

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !skid_full)
		else $error("Result produced while the skid stage is full.");

	a_sel_capmt: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_res.selects_service) |-> out_res.is_capmt)
		else $error("Selected service without a CA PMT tag.");

	a_switch_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_res.switch_request) |-> out_res.selects_service)
		else $error("Switch request without a selected service.");

	a_oversize: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_res.oversize) |-> !out_res.selects_service)
		else $error("Oversize object reported as selected.");
`endif

endmodule

/* rtl/cpsc_parser.sv */
// Per-byte object parser: header, length, body field capture and descriptor walk.
// Depends on cpsc_pkg for the phase enum, tag constants and the result struct.

module cpsc_parser #(
	parameter int MAX_OBJECT_BYTES = cpsc_pkg::DEF_MAX_OBJECT_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [7:0]             rx_byte,
	input  logic                   restart,
	output logic                   res_valid,
	output cpsc_pkg::cpsc_result_t res
);

	localparam int POS_W = $clog2(MAX_OBJECT_BYTES);
	// Offsets reach a body position plus a full stream header and info length.
	localparam int OFF_W = $clog2(MAX_OBJECT_BYTES + 4102);

	typedef struct packed {
		cpsc_pkg::cpsc_phase_t phase;
		logic [1:0]       hdr_cnt;
		logic [23:0]      header;
		logic [6:0]       len_left;
		logic [6:0]       ext_count;
		logic [31:0]      body_len;
		logic [POS_W-1:0] pos;
		logic [7:0]       list_mode;
		logic [11:0]      prog_info_len;
		logic [OFF_W-1:0] next_desc;
		logic [OFF_W-1:0] next_stream;
		logic [OFF_W-1:0] stream_end;
		logic [OFF_W-1:0] stream_base;
		logic [OFF_W-1:0] priv_at;
		logic             ca_seen;
		logic             accepted;
		logic             prog_len_next;
		logic             es_len_next;
		logic             priv_tag;
		logic             priv_on;
		logic [7:0]       priv_hi;
		logic [15:0]      pend_prog;
		logic [15:0]      pend_prov;
	} parse_t;

	parse_t ps_q, ps_d;
	logic [15:0] prog_hold_q, prog_hold_d;
	logic [15:0] prov_hold_q, prov_hold_d;
	logic fta_hold_q, fta_hold_d;
	logic startup_q, startup_d;

	logic len_done, fin, fin_over, clear, stop, sel, sw;
	logic [OFF_W-1:0] off, prog_end;
	logic [33:0] total;

	always_comb begin
		ps_d = ps_q;
		prog_hold_d = prog_hold_q;
		prov_hold_d = prov_hold_q;
		fta_hold_d = fta_hold_q;
		startup_d = startup_q;
		len_done = 1'b0;
		fin = 1'b0;
		fin_over = 1'b0;
		clear = 1'b0;
		stop = 1'b0;
		sel = 1'b0;
		sw = 1'b0;
		off = OFF_W'(ps_q.pos);
		prog_end = '0;
		total = '0;
		res = '0;
		if (restart) begin
			clear = 1'b1;
		end else begin
			unique case (ps_q.phase)
				cpsc_pkg::PH_HEADER: begin
					if (ps_q.hdr_cnt != 2'd3) begin
						ps_d.header = {ps_q.header[15:0], rx_byte};
						ps_d.hdr_cnt = ps_q.hdr_cnt + 2'd1;
					end else if (rx_byte[cpsc_pkg::LEN_EXT_BIT]) begin
						ps_d.ext_count = rx_byte[6:0];
						ps_d.len_left = rx_byte[6:0];
						ps_d.body_len = '0;
						if (rx_byte[6:0] == 7'd0) begin
							len_done = 1'b1;
						end else begin
							ps_d.phase = cpsc_pkg::PH_LENGTH;
						end
					end else begin
						ps_d.body_len = 32'(rx_byte[6:0]);
						len_done = 1'b1;
					end
				end
				cpsc_pkg::PH_LENGTH: begin
					if (ps_q.body_len > 32'h00FF_FFFF) begin
						ps_d.body_len = '1;
					end else begin
						ps_d.body_len = {ps_q.body_len[23:0], rx_byte};
					end
					ps_d.len_left = ps_q.len_left - 7'd1;
					if (ps_d.len_left == 7'd0) begin
						len_done = 1'b1;
					end
				end
				cpsc_pkg::PH_BODY: begin
					unique case (ps_q.pos)
						POS_W'(0): ps_d.list_mode = rx_byte;
						POS_W'(1): ps_d.pend_prog = {rx_byte, 8'h00};
						POS_W'(2): ps_d.pend_prog = {ps_q.pend_prog[15:8], rx_byte};
						POS_W'(4): ps_d.prog_info_len = {rx_byte[3:0], 8'h00};
						POS_W'(5): begin
							ps_d.prog_info_len = {ps_q.prog_info_len[11:8], rx_byte};
							ps_d.next_stream = OFF_W'(ps_d.prog_info_len) + OFF_W'(6);
							ps_d.next_desc = OFF_W'(7);
						end
						POS_W'(6): begin
							ps_d.accepted = (ps_q.header == cpsc_pkg::CAPMT_TAG) &&
								(rx_byte == cpsc_pkg::CMD_DESCRAMBLE_OK) &&
								(ps_q.list_mode == cpsc_pkg::LM_FIRST ||
								 ps_q.list_mode == cpsc_pkg::LM_ONLY ||
								 ps_q.list_mode == cpsc_pkg::LM_UPDATE);
						end
						default: begin
						end
					endcase
					if (ps_d.accepted && ps_q.pos >= POS_W'(6)) begin
						if (ps_q.priv_on) begin
							if (off == ps_q.priv_at) begin
								ps_d.priv_hi = rx_byte;
							end else if (off == ps_q.priv_at + OFF_W'(1)) begin
								ps_d.pend_prov = {ps_q.priv_hi, rx_byte};
								ps_d.priv_on = 1'b0;
							end
						end
						if (!ps_q.ca_seen) begin
							prog_end = OFF_W'(ps_d.prog_info_len) + OFF_W'(6);
							if (ps_q.prog_len_next) begin
								ps_d.prog_len_next = 1'b0;
								ps_d.next_desc = off + OFF_W'(1) + OFF_W'(rx_byte);
								if (ps_q.priv_tag) begin
									ps_d.priv_tag = 1'b0;
									if (rx_byte >= cpsc_pkg::PRIV_MIN_LEN) begin
										ps_d.priv_on = 1'b1;
										ps_d.priv_at = off + OFF_W'(7);
									end
								end
							end else if (off < prog_end && off == ps_d.next_desc) begin
								if (rx_byte == cpsc_pkg::TAG_CA) begin
									ps_d.ca_seen = 1'b1;
									stop = 1'b1;
								end else begin
									ps_d.priv_tag = (rx_byte == cpsc_pkg::TAG_PRIVATE);
									ps_d.prog_len_next = 1'b1;
								end
							end
							if (!stop && off >= prog_end) begin
								if (ps_q.es_len_next) begin
									ps_d.es_len_next = 1'b0;
									ps_d.next_desc = off + OFF_W'(1) + OFF_W'(rx_byte);
								end else if (off >= ps_q.stream_base + OFF_W'(6) &&
									off < ps_q.stream_end && off == ps_d.next_desc) begin
									if (rx_byte == cpsc_pkg::TAG_CA) begin
										ps_d.ca_seen = 1'b1;
										stop = 1'b1;
									end else begin
										ps_d.es_len_next = 1'b1;
									end
								end
								if (!stop) begin
									if (off == ps_q.next_stream) begin
										ps_d.stream_base = off;
										ps_d.stream_end = '0;
									end else if (off == ps_q.stream_base + OFF_W'(3)) begin
										ps_d.stream_end = OFF_W'({rx_byte[3:0], 8'h00});
									end else if (off == ps_q.stream_base + OFF_W'(4)) begin
										ps_d.stream_end = ps_q.stream_base + OFF_W'(5) +
											(ps_q.stream_end | OFF_W'(rx_byte));
										ps_d.next_stream = ps_d.stream_end;
										ps_d.next_desc = ps_q.stream_base + OFF_W'(6);
										ps_d.es_len_next = 1'b0;
									end
								end
							end
						end
					end
					ps_d.pos = ps_q.pos + POS_W'(1);
					if (32'(ps_d.pos) >= ps_q.body_len) begin
						fin = 1'b1;
					end
				end
				cpsc_pkg::PH_SKIP: begin
					ps_d.body_len = ps_q.body_len - 32'd1;
					if (ps_d.body_len == 32'd0) begin
						fin = 1'b1;
						fin_over = 1'b1;
					end
				end
			endcase

			if (len_done) begin
				total = 34'd4 + 34'(ps_d.ext_count) + 34'(ps_d.body_len);
				if (total > 34'(MAX_OBJECT_BYTES)) begin
					if (ps_d.body_len == 32'd0) begin
						fin = 1'b1;
						fin_over = 1'b1;
					end else begin
						ps_d.phase = cpsc_pkg::PH_SKIP;
					end
				end else if (ps_d.body_len == 32'd0) begin
					fin = 1'b1;
				end else begin
					ps_d.phase = cpsc_pkg::PH_BODY;
					ps_d.pos = '0;
				end
			end

			if (fin) begin
				sel = ps_d.accepted && !fin_over;
				if (sel) begin
					prog_hold_d = ps_d.pend_prog;
					prov_hold_d = ps_d.pend_prov;
					fta_hold_d = !ps_d.ca_seen;
					if (startup_q || ps_d.ca_seen) begin
						sw = 1'b1;
						startup_d = 1'b0;
					end
				end
				res.is_capmt = (ps_d.header == cpsc_pkg::CAPMT_TAG);
				res.selects_service = sel;
				res.program_number = prog_hold_d;
				res.provider_id = prov_hold_d;
				res.free_to_air = fta_hold_d;
				res.switch_request = sw;
				res.oversize = fin_over;
				clear = 1'b1;
			end
		end
		if (clear) begin
			ps_d = '0;
		end
		res_valid = en && fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q <= '0;
			prog_hold_q <= '0;
			prov_hold_q <= '0;
			fta_hold_q <= 1'b0;
			startup_q <= 1'b1;
		end else if (en) begin
			ps_q <= ps_d;
			prog_hold_q <= prog_hold_d;
			prov_hold_q <= prov_hold_d;
			fta_hold_q <= fta_hold_d;
			startup_q <= startup_d;
		end
	end

endmodule

/* rtl/cpsc_out_buf.sv */
// Result register with a one-word skid stage between the parser and the output stream.
// Depends on cpsc_pkg for the result struct.

module cpsc_out_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  cpsc_pkg::cpsc_result_t in_data,
	input  logic                   out_ready,
	output logic                   out_valid,
	output cpsc_pkg::cpsc_result_t out_data,
	output logic                   skid_full
);

	logic out_valid_q, skid_valid_q, out_free;
	cpsc_pkg::cpsc_result_t out_data_q, skid_data_q;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else begin
			skid_valid_q <= skid_valid_q || in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (in_valid) begin
				out_data_q <= in_data;
			end
		end
		if (in_valid && !out_free) begin
			skid_data_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign skid_full = skid_valid_q;

endmodule

/* tb/cpsc_checker.sv */
// Result checker for the CA PMT service classifier: watches both stream ports,
// predicts each object result from the accepted input words and compares them.
// Depends on cpsc_pkg for the result layout and the protocol constants.
`timescale 1ns / 100ps

module cpsc_checker #(
	parameter int MAX_OBJECT_BYTES = cpsc_pkg::DEF_MAX_OBJECT_BYTES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // rx_byte[7:0]
	input  logic                             s_tuser,  // restart
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	// is_capmt, selects_service, program_number[15:0], provider_id[15:0],
	// free_to_air, switch_request, oversize, zero padding
	input  logic [cpsc_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int                               fail_count,
	output int                               results_due
);

	cpsc_pkg::cpsc_phase_t  ph;
	int unsigned  pos, hdr, len_left, ext_cnt, body_len, lm, cmd_byte, pil;
	int unsigned  desc_at, strm_at, es_end, strm_base, prov_at, prov_hi;
	int unsigned  new_prog, new_prov;
	logic [15:0]  prog_held, prov_held;
	bit           ca_found, taken, pil_len_next, es_len_next, priv_pending, prov_armed;
	bit           fta_held, first_pending;
	cpsc_pkg::cpsc_result_t finished_object;
	cpsc_pkg::cpsc_result_t object_results_due[$];

	function automatic void drop_partial();
		ph = cpsc_pkg::PH_HEADER;
		pos = 0;
		hdr = 0;
		len_left = 0;
		ext_cnt = 0;
		body_len = 0;
		lm = 0;
		cmd_byte = 0;
		pil = 0;
		desc_at = 0;
		strm_at = 0;
		es_end = 0;
		strm_base = 0;
		ca_found = 0;
		taken = 0;
		pil_len_next = 0;
		es_len_next = 0;
		priv_pending = 0;
		prov_armed = 0;
		prov_at = 0;
		prov_hi = 0;
		new_prog = 0;
		new_prov = 0;
	endfunction

	function automatic void reset_model();
		drop_partial();
		prog_held = '0;
		prov_held = '0;
		fta_held = 0;
		first_pending = 1;
	endfunction

	// Held values change only when an accepted object ends in full.
	function automatic void close_object(input bit over);
		bit sel;
		bit sw;
		sel = taken && !over;
		sw = 0;
		if (sel) begin
			prog_held = new_prog[15:0];
			prov_held = new_prov[15:0];
			fta_held = !ca_found;
			if (first_pending || !fta_held) begin
				sw = 1;
				first_pending = 0;
			end
		end
		finished_object.is_capmt = (hdr == cpsc_pkg::CAPMT_TAG);
		finished_object.selects_service = sel;
		finished_object.program_number = prog_held;
		finished_object.provider_id = prov_held;
		finished_object.free_to_air = fta_held;
		finished_object.switch_request = sw;
		finished_object.oversize = over;
		drop_partial();
	endfunction

	function automatic bit end_of_length();
		longint unsigned total;
		total = 64'd4 + 64'(ext_cnt) + 64'(body_len);
		if (total > MAX_OBJECT_BYTES) begin
			if (body_len == 0) begin
				close_object(1);
				return 1;
			end
			ph = cpsc_pkg::PH_SKIP;
			return 0;
		end
		if (body_len == 0) begin
			close_object(0);
			return 1;
		end
		ph = cpsc_pkg::PH_BODY;
		pos = 0;
		return 0;
	endfunction

	function automatic void parse_body_byte(input int unsigned o, input int unsigned b);
		case (o)
			0: lm = b;
			1: new_prog = b << 8;
			2: new_prog = new_prog | b;
			4: pil = (b & 'hF) << 8;
			5: begin
				pil = pil | b;
				strm_at = pil + 6;
				desc_at = 7;
			end
			6: begin
				cmd_byte = b;
				taken = hdr == cpsc_pkg::CAPMT_TAG && b == cpsc_pkg::CMD_DESCRAMBLE_OK &&
					(lm == cpsc_pkg::LM_FIRST || lm == cpsc_pkg::LM_ONLY ||
					 lm == cpsc_pkg::LM_UPDATE);
			end
			default: ;
		endcase
		if (!taken || o < 6) return;

		if (prov_armed) begin
			if (o == prov_at) begin
				prov_hi = b;
			end else if (o == prov_at + 1) begin
				new_prov = (prov_hi << 8) | b;
				prov_armed = 0;
			end
		end
		if (ca_found) return;

		// Descriptors of the program loop.
		if (pil_len_next) begin
			pil_len_next = 0;
			desc_at = o + 1 + b;
			if (priv_pending) begin
				priv_pending = 0;
				if (b >= cpsc_pkg::PRIV_MIN_LEN) begin
					prov_armed = 1;
					prov_at = o + 7;
				end
			end
		end else if (o < pil + 6 && o == desc_at) begin
			if (b == cpsc_pkg::TAG_CA) begin
				ca_found = 1;
				return;
			end
			priv_pending = (b == cpsc_pkg::TAG_PRIVATE);
			pil_len_next = 1;
		end

		// Elementary streams and their descriptors.
		if (o >= pil + 6) begin
			if (es_len_next) begin
				es_len_next = 0;
				desc_at = o + 1 + b;
			end else if (o >= strm_base + 6 && o < es_end && o == desc_at) begin
				if (b == cpsc_pkg::TAG_CA) begin
					ca_found = 1;
					return;
				end
				es_len_next = 1;
			end
			if (o == strm_at) begin
				strm_base = o;
				es_end = 0;
			end else if (o == strm_base + 3) begin
				es_end = (b & 'hF) << 8;
			end else if (o == strm_base + 4) begin
				es_end = strm_base + 5 + (es_end | b);
				strm_at = es_end;
				desc_at = strm_base + 6;
				es_len_next = 0;
			end
		end
	endfunction

	// Returns 1 when the word ends an object; the result is then in finished_object.
	function automatic bit classify_byte(input logic [7:0] rx, input logic rst);
		int unsigned b;
		b = rx;
		if (rst) begin
			drop_partial();
			return 0;
		end
		case (ph)
			cpsc_pkg::PH_HEADER: begin
				if (pos < 3) begin
					hdr = ((hdr << 8) | b) & 'hFFFFFF;
					pos++;
					return 0;
				end
				if (b[cpsc_pkg::LEN_EXT_BIT]) begin
					ext_cnt = b & 'h7F;
					len_left = ext_cnt;
					body_len = 0;
					if (ext_cnt == 0) return end_of_length();
					ph = cpsc_pkg::PH_LENGTH;
					return 0;
				end
				body_len = b & 'h7F;
				return end_of_length();
			end
			cpsc_pkg::PH_LENGTH: begin
				if (body_len > 'hFFFFFF) body_len = 'hFFFFFFFF;
				else body_len = (body_len << 8) | b;
				len_left--;
				if (len_left == 0) return end_of_length();
				return 0;
			end
			cpsc_pkg::PH_BODY: begin
				parse_body_byte(pos, b);
				pos++;
				if (pos >= body_len) begin
					close_object(0);
					return 1;
				end
				return 0;
			end
			default: begin
				body_len--;
				if (body_len == 0) begin
					close_object(1);
					return 1;
				end
				return 0;
			end
		endcase
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	initial fail_count = 0;

	always @(posedge clk) begin : watch
		cpsc_pkg::cpsc_result_t want;
		if (!arst_n) begin
			reset_model();
			object_results_due.delete();
		end else begin
			if (s_tvalid && s_tready && classify_byte(s_tdata, s_tuser))
				object_results_due.push_back(finished_object);
			if (m_tvalid && m_tready) begin
				if (object_results_due.size() == 0) begin
					$display("%0t ns: result word expected none, actual 0x%h", $time, m_tdata);
					fail_count++;
				end else begin
					want = object_results_due.pop_front();
					check_field("is_capmt", want.is_capmt, m_tdata[0]);
					check_field("selects_service", want.selects_service, m_tdata[1]);
					check_field("program_number", want.program_number, m_tdata[17:2]);
					check_field("provider_id", want.provider_id, m_tdata[33:18]);
					check_field("free_to_air", want.free_to_air, m_tdata[34]);
					check_field("switch_request", want.switch_request, m_tdata[35]);
					check_field("oversize", want.oversize, m_tdata[36]);
					check_field("padding", 0, m_tdata[cpsc_pkg::OUT_TDATA_W-1:37]);
				end
			end
		end
		results_due = object_results_due.size();
	end

endmodule

/* tb/tb_ca_pmt_service_classifier.sv */
// Top of the CA PMT service classifier testbench: builds directed and random TLV
// byte streams, drives them with random gaps and stalls and gives the verdict.
// Depends on cpsc_pkg, the ca_pmt_service_classifier RTL and cpsc_checker.
`timescale 1ns / 100ps

module tb_ca_pmt_service_classifier;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int STIM_WORDS = 1700;

	typedef struct packed {
		logic       drain;
		logic       rst;
		logic [7:0] b;
	} stim_word_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [7:0]                       s_tdata;  // rx_byte[7:0]
	logic                             s_tuser;  // restart
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	// is_capmt, selects_service, program_number[15:0], provider_id[15:0],
	// free_to_air, switch_request, oversize, zero padding
	logic [cpsc_pkg::OUT_TDATA_W-1:0] m_tdata;
	int                               fail_count;
	int                               results_due;
	logic                             calm;
	int                               stall_cycles = 0;

	stim_word_t stim_q[$];
	logic [7:0] body_buf[$];
	bit         drain_next;
	int         priv_pos;

	ca_pmt_service_classifier uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	cpsc_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 20);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] filler_tag();
		logic [7:0] t;
		do t = rnd_byte(); while (t == cpsc_pkg::TAG_CA || t == cpsc_pkg::TAG_PRIVATE);
		return t;
	endfunction

	task automatic push_word(input logic [7:0] b, input logic rst);
		stim_q.push_back({drain_next, rst, b});
		drain_next = 0;
	endtask

	task automatic add_desc(input logic [7:0] tag, input int len);
		body_buf.push_back(tag);
		body_buf.push_back(8'(len));
		repeat (len) body_buf.push_back(rnd_byte());
	endtask

	// Lays out a CA PMT body with a program loop and n_streams stream entries.
	// ca_where: 0 none, 1 program loop, 2 last stream; priv_len below 0 leaves
	// out the private descriptor.
	task automatic build_capmt_body(input logic [7:0] lm, input logic [7:0] cmd,
			input logic [15:0] prog, input int ca_where, input int priv_len,
			input int n_streams);
		int pil;
		int s;
		int eil;
		int i;
		body_buf.delete();
		body_buf.push_back(lm);
		body_buf.push_back(prog[15:8]);
		body_buf.push_back(prog[7:0]);
		body_buf.push_back(rnd_byte());
		body_buf.push_back(8'h00);
		body_buf.push_back(8'h00);
		body_buf.push_back(cmd);
		repeat ($urandom_range(0, 2)) add_desc(filler_tag(), $urandom_range(0, 6));
		priv_pos = body_buf.size();
		if (priv_len >= 0) add_desc(cpsc_pkg::TAG_PRIVATE, priv_len);
		if (ca_where == 1) add_desc(cpsc_pkg::TAG_CA, $urandom_range(4, 8));
		if ($urandom_range(0, 3) == 0) add_desc(filler_tag(), $urandom_range(0, 6));
		pil = body_buf.size() - 6;
		body_buf[4] = {4'($urandom_range(0, 15)), 4'(pil >> 8)};
		body_buf[5] = 8'(pil);
		for (i = 0; i < n_streams; i++) begin
			s = body_buf.size();
			repeat (3) body_buf.push_back(rnd_byte());
			body_buf.push_back(8'h00);
			body_buf.push_back(8'h00);
			body_buf.push_back(rnd_byte());
			repeat ($urandom_range(0, 2)) add_desc(filler_tag(), $urandom_range(0, 6));
			if (ca_where == 2 && i == n_streams - 1)
				add_desc(cpsc_pkg::TAG_CA, $urandom_range(4, 8));
			eil = body_buf.size() - s - 5;
			body_buf[s + 3] = {4'($urandom_range(0, 15)), 4'(eil >> 8)};
			body_buf[s + 4] = 8'(eil);
		end
	endtask

	// Sends tag, length and body_buf. len_form: 0 short, 1 one length byte,
	// 2 two length bytes, 3 long form with no length bytes for an empty body.
	// A cut_at of 0 or more replaces that word and the rest with a restart word.
	task automatic send_object(input logic [23:0] tag, input int len_form, input int cut_at);
		logic [7:0] obj_q[$];
		int n;
		int k;
		n = body_buf.size();
		obj_q.push_back(tag[23:16]);
		obj_q.push_back(tag[15:8]);
		obj_q.push_back(tag[7:0]);
		if (n == 0 && len_form == 3) begin
			obj_q.push_back(8'h80);
		end else if (n < 128 && len_form == 0) begin
			obj_q.push_back(8'(n));
		end else if (n < 256 && len_form == 1) begin
			obj_q.push_back(8'h81);
			obj_q.push_back(8'(n));
		end else begin
			obj_q.push_back(8'h82);
			obj_q.push_back(8'(n >> 8));
			obj_q.push_back(8'(n));
		end
		for (k = 0; k < n; k++) obj_q.push_back(body_buf[k]);
		for (k = 0; k < obj_q.size(); k++) begin
			if (k == cut_at) begin
				push_word(rnd_byte(), 1'b1);
				return;
			end
			push_word(obj_q[k], 1'b0);
		end
	endtask

	task automatic truncate_body(input int keep);
		while (body_buf.size() > keep) void'(body_buf.pop_back());
	endtask

	task automatic build_directed();
		body_buf.delete();
		send_object(cpsc_pkg::CAPMT_TAG, 0, -1);
		body_buf.delete();
		send_object(24'h123456, 3, -1);
		// First accepted service: free to air, with a provider word.
		build_capmt_body(cpsc_pkg::LM_ONLY, cpsc_pkg::CMD_DESCRAMBLE_OK, 16'hFFFF, 0, 8, 1);
		send_object(cpsc_pkg::CAPMT_TAG, 0, -1);
		build_capmt_body(cpsc_pkg::LM_FIRST, cpsc_pkg::CMD_DESCRAMBLE_OK, 16'h0000, 0, -1, 2);
		send_object(cpsc_pkg::CAPMT_TAG, 1, -1);
		build_capmt_body(cpsc_pkg::LM_UPDATE, cpsc_pkg::CMD_DESCRAMBLE_OK, 16'h1234, 1, 10, 1);
		send_object(cpsc_pkg::CAPMT_TAG, 2, -1);
		build_capmt_body(cpsc_pkg::LM_ONLY, cpsc_pkg::CMD_DESCRAMBLE_OK, 16'hA5C3, 2, -1, 2);
		send_object(cpsc_pkg::CAPMT_TAG, 0, -1);
		build_capmt_body(cpsc_pkg::LM_ONLY, 8'h03, 16'h0101, 1, 9, 1);
		send_object(cpsc_pkg::CAPMT_TAG, 0, -1);
		build_capmt_body(8'h02, cpsc_pkg::CMD_DESCRAMBLE_OK, 16'h0202, 1, 9, 1);
		send_object(cpsc_pkg::CAPMT_TAG, 0, -1);
		build_capmt_body(cpsc_pkg::LM_ONLY, cpsc_pkg::CMD_DESCRAMBLE_OK, 16'h0303, 1, 9, 1);
		send_object(24'h9F8033, 0, -1);
		// Body too short to hold the command byte.
		build_capmt_body(cpsc_pkg::LM_ONLY, cpsc_pkg::CMD_DESCRAMBLE_OK, 16'h0404, 1, -1, 0);
		truncate_body(5);
		send_object(cpsc_pkg::CAPMT_TAG, 0, -1);
		// Private descriptor too short to carry a provider word.
		build_capmt_body(cpsc_pkg::LM_ONLY, cpsc_pkg::CMD_DESCRAMBLE_OK, 16'h0505, 0, 7, 1);
		send_object(cpsc_pkg::CAPMT_TAG, 0, -1);
		// Provider word cut off by the end of the body.
		build_capmt_body(cpsc_pkg::LM_FIRST, cpsc_pkg::CMD_DESCRAMBLE_OK, 16'h0606, 1, 12, 1);
		truncate_body(priv_pos + 9);
		send_object(cpsc_pkg::CAPMT_TAG, 0, -1);
		// Restart in the middle of an accepted object.
		build_capmt_body(cpsc_pkg::LM_ONLY, cpsc_pkg::CMD_DESCRAMBLE_OK, 16'h0707, 1, 8, 1);
		send_object(cpsc_pkg::CAPMT_TAG, 0, 12);
		// Saturating length, a few skipped words, then a restart.
		push_word(8'h9F, 1'b0);
		push_word(8'h80, 1'b0);
		push_word(8'h32, 1'b0);
		push_word(8'h85, 1'b0);
		repeat (5) push_word(8'hFF, 1'b0);
		repeat (3) push_word(rnd_byte(), 1'b0);
		push_word(rnd_byte(), 1'b1);
		body_buf.delete();
		body_buf.push_back(8'hFF);
		body_buf.push_back(8'h00);
		send_object(24'h000000, 0, -1);
		body_buf.delete();
		body_buf.push_back(8'h00);
		body_buf.push_back(8'hFF);
		send_object(24'hFFFFFF, 1, -1);
	endtask

	task automatic build_random();
		int objs;
		int pick;
		int ca_where;
		int n_streams;
		int priv_len;
		int cut_at;
		logic [23:0] tag;
		logic [7:0] lm;
		logic [7:0] cmd;
		logic [7:0] modes[3];
		modes[0] = cpsc_pkg::LM_FIRST;
		modes[1] = cpsc_pkg::LM_ONLY;
		modes[2] = cpsc_pkg::LM_UPDATE;
		objs = 0;
		while (stim_q.size() < STIM_WORDS) begin
			objs++;
			if (objs == 5 || objs == 20) drain_next = 1;
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				body_buf.delete();
				repeat ($urandom_range(0, 20)) body_buf.push_back(rnd_byte());
				send_object(24'($urandom()), $urandom_range(0, 3), -1);
			end else if (pick < 12) begin
				repeat ($urandom_range(1, 10)) push_word(rnd_byte(), 1'b0);
				push_word(rnd_byte(), 1'b1);
			end else if (pick < 14) begin
				push_word(rnd_byte(), 1'b1);
			end else begin
				tag = cpsc_pkg::CAPMT_TAG;
				if ($urandom_range(0, 99) < 5)
					tag = cpsc_pkg::CAPMT_TAG ^ (24'd1 << $urandom_range(0, 23));
				else if ($urandom_range(0, 99) < 5) tag = 24'($urandom());
				lm = ($urandom_range(0, 99) < 80) ? modes[$urandom_range(0, 2)] : rnd_byte();
				cmd = ($urandom_range(0, 99) < 85) ? cpsc_pkg::CMD_DESCRAMBLE_OK : rnd_byte();
				ca_where = $urandom_range(0, 2);
				n_streams = $urandom_range(0, 3);
				if (ca_where == 2 && n_streams == 0) n_streams = 1;
				priv_len = ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, 12);
				build_capmt_body(lm, cmd, 16'($urandom()), ca_where, priv_len, n_streams);
				if ($urandom_range(0, 99) < 10)
					truncate_body($urandom_range(1, body_buf.size() - 1));
				if ($urandom_range(0, 99) < 5)
					body_buf[$urandom_range(0, body_buf.size() - 1)] = rnd_byte();
				cut_at = -1;
				if ($urandom_range(0, 99) < 5) cut_at = $urandom_range(0, body_buf.size() + 3);
				send_object(tag, $urandom_range(0, 2), cut_at);
			end
		end
	endtask

	initial begin
		int i;
		int n;
		int calm_lo;
		bit quiet;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tuser = 1'b0;
		calm = 1'b0;
		drain_next = 0;
		build_directed();
		build_random();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		n = stim_q.size();
		calm_lo = n / 3;
		for (i = 0; i < n; i++) begin
			quiet = (i >= calm_lo && i < calm_lo + 400);
			calm <= quiet;
			if (stim_q[i].drain) begin
				while (results_due != 0) begin
					s_tvalid <= 1'b0;
					@(negedge clk);
				end
			end
			while (!quiet && $urandom_range(0, 99) < 20) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= stim_q[i].b;
			s_tuser <= stim_q[i].rst;
			do @(posedge clk); while (!s_tready);
			@(negedge clk);
		end
		s_tvalid <= 1'b0;
		while (results_due != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0 && results_due == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
